/* sv/assert_macros.svh */
// Assertion macros shared by the turntable ramp controller RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* sv/tvrc_pkg.sv */
// Package for the turntable velocity ramp controller.
// Field widths, register defaults, register indexes and controller command type.
`timescale 1ns / 1ps

package tvrc_pkg;

    // Default velocity fraction bits (velocity is Q.F)
    localparam int DEF_VEL_FRAC_BITS = 14;

    // Field widths
    localparam int ANGLE_W   = 16;
    localparam int ELAPSED_W = 12;
    localparam int MV_W      = 12;
    localparam int VEL_OUT_W = 16;
    localparam int HEAD_W    = 48;

    // Configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int ACCEL_W    = 10;
    localparam int GAIN_W     = 8;
    localparam int DBAND_W    = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DBAND  = 2'd3;

    localparam logic               RST_ENABLE = 1'b1;
    localparam logic [ACCEL_W-1:0] RST_ACCEL  = 10'd33;
    localparam logic [GAIN_W-1:0]  RST_GAIN   = 8'd32;
    localparam logic [DBAND_W-1:0] RST_DBAND  = 15'd357;

    // DAC scaling
    localparam logic [MV_W-1:0] DAC_CENTER_MV   = 12'd1250;
    localparam logic [10:0]     DAC_MV_PER_UNIT = 11'd1244;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic capture;   // latch the input transaction
        logic tgt_en;    // form target, step and deadband region
        logic vel_en;    // ramp and saturate the velocity
        logic mul_en;    // DAC and heading products
        logic out_load;  // load result registers, integrate heading
    } t_dp_cmd;

endpackage

/* sv/tvrc_ctrl.sv */
// Sequencer for the turntable velocity ramp controller.
// Depends on tvrc_pkg and assert_macros.svh; drives the datapath commands.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tvrc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output tvrc_pkg::t_dp_cmd o_cmd
);
    import tvrc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TGT  = 3'd1;
    localparam logic [2:0] S_VEL  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;
    logic       w_accept;

    assign w_out_free = !r_out_valid || i_m_tready;
    // take nothing while reset is held
    assign o_s_tready = i_rst_n &&
                        ((r_state == S_IDLE) || ((r_state == S_OUT) && w_out_free));
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.capture  = w_accept;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_TGT;
            end
            S_TGT: begin
                o_cmd.tgt_en = 1'b1;
                n_state      = S_VEL;
            end
            S_VEL: begin
                o_cmd.vel_en = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                // hold until the result register is free
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = w_accept ? S_TGT : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `ASSERT_IMPLIES(a_load_when_free, i_clk, i_rst_n, o_cmd.out_load, w_out_free)
    `ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept, r_state == S_TGT)
    `ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, o_cmd.out_load, r_out_valid)

endmodule

/* sv/tvrc_dp.sv */
// Datapath for the turntable velocity ramp controller: config registers,
// target, ramp, DAC scaling and heading integration. Depends on tvrc_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tvrc_dp #(
    parameter int VELOCITY_FRAC_BITS = tvrc_pkg::DEF_VEL_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tvrc_pkg::t_dp_cmd                    i_cmd,
    input  logic                                 i_cfg_we,
    input  logic [tvrc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tvrc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [tvrc_pkg::ANGLE_W-1:0]  i_angle,
    input  logic [tvrc_pkg::ELAPSED_W-1:0]       i_elapsed,
    output logic [tvrc_pkg::MV_W-1:0]            o_mv,
    output logic signed [tvrc_pkg::VEL_OUT_W-1:0] o_vel,
    output logic signed [tvrc_pkg::HEAD_W-1:0]   o_heading
);
    import tvrc_pkg::*;

    localparam int P   = VELOCITY_FRAC_BITS;
    localparam int VW  = P + 2;                          // saturated velocity
    localparam int SW  = ACCEL_W + ELAPSED_W;            // step size
    localparam int PW  = ANGLE_W + GAIN_W + 1;           // negated gain*angle
    localparam int TW  = (P > 16) ? PW + P - 16 : PW;    // target velocity
    localparam int IW  = ((P > SW) ? P : SW) + 3;        // ramp intermediate
    localparam int CW  = ((IW > TW) ? IW : TW) + 1;      // compare width
    localparam int MW  = VW + 11;                        // velocity * 1244
    localparam int HW  = VW + ELAPSED_W + 1;             // velocity * ms
    localparam int AW  = ANGLE_W + 1;                    // angle vs deadband

    localparam logic signed [VW-1:0] VEL_ONE  = {{(VW-P-1){1'b0}}, 1'b1, {P{1'b0}}};
    localparam logic signed [VW-1:0] VEL_MIN  = -VEL_ONE;
    localparam logic signed [CW-1:0] CMP_ONE  = CW'(VEL_ONE);
    localparam logic signed [CW-1:0] CMP_MIN  = CW'(VEL_MIN);
    localparam logic signed [MW-1:0] MV_HALF  = {{(MW-P){1'b0}}, 1'b1, {(P-1){1'b0}}};

    // configuration
    logic               r_enable;
    logic [ACCEL_W-1:0] r_accel;
    logic [GAIN_W-1:0]  r_gain;
    logic [DBAND_W-1:0] r_dband;

    // captured transaction
    logic signed [ANGLE_W-1:0] r_angle;
    logic [ELAPSED_W-1:0]      r_elapsed;

    // target stage
    logic [SW-1:0]           r_step;
    logic signed [TW-1:0]    r_target;
    logic                    r_above, r_below;
    logic signed [PW-1:0]    w_gprod, w_neg;
    logic signed [TW-1:0]    w_target;
    logic signed [AW-1:0]    w_a17, w_db17;

    // velocity stage
    logic signed [VW-1:0]    r_vel;
    logic signed [CW-1:0]    w_v0, w_v1, w_v2, w_t, w_s, w_sat;

    // product stage
    logic signed [MW-1:0]    r_mvprod;
    logic signed [HW-1:0]    r_hdprod;
    logic signed [MW-1:0]    w_mvsh;

    // result registers
    logic [MV_W-1:0]             r_mv;
    logic signed [VEL_OUT_W-1:0] r_vel_out;
    logic [HEAD_W-1:0]           r_heading;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= RST_ENABLE;
            r_accel  <= RST_ACCEL;
            r_gain   <= RST_GAIN;
            r_dband  <= RST_DBAND;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_ACCEL:  r_accel  <= i_cfg_data[ACCEL_W-1:0];
                CFG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_DBAND:  r_dband  <= i_cfg_data[DBAND_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_angle   <= i_angle;
            r_elapsed <= i_elapsed;
        end
    end

    // target = floor(-(gain*angle) / 2^(16-F)), exact shift up when F > 16
    assign w_gprod = $signed({1'b0, r_gain}) * r_angle;
    assign w_neg   = -w_gprod;

    generate
        if (P <= 16) begin : g_tgt_down
            assign w_target = TW'(w_neg >>> (16 - P));
        end else begin : g_tgt_up
            assign w_target = TW'(w_neg) <<< (P - 16);
        end
    endgenerate

    assign w_a17  = AW'(r_angle);
    assign w_db17 = $signed({2'b00, r_dband});

    always_ff @(posedge i_clk) begin
        if (i_cmd.tgt_en) begin
            r_step   <= r_accel * r_elapsed;
            r_target <= w_target;
            r_above  <= w_a17 > w_db17;
            r_below  <= w_a17 < -w_db17;
        end
    end

    // ramp: two ordered checks outside the deadband, decay inside it
    assign w_v0 = CW'(r_vel);
    assign w_t  = CW'(r_target);
    assign w_s  = $signed(CW'(r_step));

    always_comb begin
        w_v1 = w_v0;
        w_v2 = w_v0;
        if (r_above) begin
            w_v1 = (w_v0 > w_t) ? w_v0 - w_s : w_v0;
            w_v2 = (w_v1 < w_t) ? w_v1 + w_s : w_v1;
        end else if (r_below) begin
            w_v1 = (w_v0 < w_t) ? w_v0 + w_s : w_v0;
            w_v2 = (w_v1 > w_t) ? w_v1 - w_s : w_v1;
        end else if (w_v0 < 0) begin
            w_v1 = w_v0 + w_s;
            w_v2 = (w_v1 > 0) ? '0 : w_v1;
        end else if (w_v0 > 0) begin
            w_v1 = w_v0 - w_s;
            w_v2 = (w_v1 < 0) ? '0 : w_v1;
        end
    end

    always_comb begin
        priority if (w_v2 > CMP_ONE) begin
            w_sat = CMP_ONE;
        end else if (w_v2 < CMP_MIN) begin
            w_sat = CMP_MIN;
        end else begin
            w_sat = w_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel <= '0;
        end else if (i_cmd.vel_en) begin
            r_vel <= w_sat[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_mvprod <= r_vel * $signed({1'b0, DAC_MV_PER_UNIT}) + MV_HALF;
            r_hdprod <= r_vel * $signed({1'b0, r_elapsed});
        end
    end

    assign w_mvsh = r_mvprod >>> P;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_mv      <= r_enable ? (w_mvsh[MV_W-1:0] + DAC_CENTER_MV) : DAC_CENTER_MV;
            // sign-extend a narrow velocity, keep the low bits of a wide one
            r_vel_out <= VEL_OUT_W'(r_vel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= '0;
        end else if (i_cmd.out_load) begin
            r_heading <= r_heading + HEAD_W'(r_hdprod);
        end
    end

    assign o_mv      = r_mv;
    assign o_vel     = r_vel_out;
    assign o_heading = $signed(r_heading);

    `ASSERT_ALWAYS(a_vel_in_range, i_clk, i_rst_n, (r_vel <= VEL_ONE) && (r_vel >= VEL_MIN))
    `ASSERT_NEXT(a_disabled_center, i_clk, i_rst_n, i_cmd.out_load && !r_enable, r_mv == DAC_CENTER_MV)

endmodule

/* sv/turntable_velocity_ramp_controller_top.sv */
// Top level of the turntable velocity ramp controller.
// Depends on tvrc_pkg, tvrc_ctrl and tvrc_dp.
`timescale 1ns / 1ps

// Each input transaction carries a heading error (signed Q4.12 radians) and the
// milliseconds since the previous update; each one yields exactly one result
// transaction with the DAC drive in millivolts (1250 is stop), the new turn
// velocity (signed Q.F, F = VELOCITY_FRAC_BITS) and the integrated heading.
// An item goes through four sequencer steps: target and step, velocity ramp
// with saturation, DAC and heading products, then result load. The
// next item enters no sooner than the last one's result load step, the pace set
// by the velocity feedback through those four steps; a result waiting on the
// output register holds the last step, and the next item enters as it is taken.
// Configuration writes land at once; the user must keep them to idle periods
// only, left to the user by the block. No memory, no clearing pass after reset.

module turntable_velocity_ramp_controller_top #(
    parameter int VELOCITY_FRAC_BITS = tvrc_pkg::DEF_VEL_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side: [15:0] user_angle, [27:16] elapsed_ms, [31:28] zero
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [31:0]                        s_axis_tdata,
    // master side: [11:0] dac_millivolts, [27:12] velocity,
    // [75:28] heading_sum, [79:76] zero
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [79:0]                        m_axis_tdata,
    // register write port
    input  logic                               i_cfg_we,
    input  logic [tvrc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tvrc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import tvrc_pkg::*;

    t_dp_cmd                     w_cmd;
    logic [MV_W-1:0]             w_mv;
    logic signed [VEL_OUT_W-1:0] w_vel;
    logic signed [HEAD_W-1:0]    w_heading;

    // sequencer: handshakes, output valid and step commands
    tvrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (w_cmd)
    );

    // datapath: registers, arithmetic and result payload
    tvrc_dp #(
        .VELOCITY_FRAC_BITS (VELOCITY_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_angle     ($signed(s_axis_tdata[ANGLE_W-1:0])),
        .i_elapsed   (s_axis_tdata[ANGLE_W +: ELAPSED_W]),
        .o_mv        (w_mv),
        .o_vel       (w_vel),
        .o_heading   (w_heading)
    );

    // pack the result fields from the lowest bit up, pad to whole bytes
    assign m_axis_tdata = {4'b0000, w_heading, w_vel, w_mv};

endmodule
